[rtl/epoch_to_calendar_datetime_core_defines.svh]
// Assertion macros for the RTL of the timestamp converter.
// Defining ASSERT_OFF removes every check from the build.
`ifndef EPOCH_TO_CALENDAR_DATETIME_CORE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATETIME_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// A property checked at every rising edge outside reset.
`define ECD_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("epoch_to_calendar_datetime_core: property failed");
// A condition that must hold in the same cycle as a trigger.
`define ECD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epoch_to_calendar_datetime_core: implication failed");
`else
`define ECD_ASSERT_PROP(lbl, clk, rst_n, prop)
`define ECD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ecd_pkg.sv]
`default_nettype none

package ecd_pkg;

    // Field widths of the input and result words.
    localparam int SEC_W   = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SECN_W  = 6;
    localparam int WDAY_W  = 3;

    // Internal widths.
    localparam int DAY_W   = 16;
    localparam int TOD_W   = 17;
    localparam int ERA_W   = 18;
    localparam int YOE_W   = 9;
    localparam int DOY_W   = 9;

    // Cycles from an accepted word to its result strobe.
    localparam int LATENCY = 9;

    // Day split: seconds >> 7 divided by 675 (86400 = 128 * 675).
    localparam logic [25:0] DAY_RCP  = 26'd50903317;
    localparam int          DAY_SH   = 35;
    localparam logic [9:0]  DAY_ODD  = 10'd675;

    // Time of day.
    localparam logic [16:0] HOUR_RCP = 17'd74566;
    localparam int          HOUR_SH  = 28;
    localparam logic [11:0] SEC_HOUR = 12'd3600;
    localparam logic [12:0] MIN_RCP  = 13'd4370;
    localparam int          MIN_SH   = 18;
    localparam logic [5:0]  SEC_MIN  = 6'd60;

    // Civil date.
    localparam logic [19:0] SHIFT_0000 = 20'd719468;
    localparam logic [19:0] ERA4_BASE  = 20'd584388;
    localparam logic [19:0] ERA5_BASE  = 20'd730485;
    localparam logic [11:0] ERA4_YEAR  = 12'd1600;
    localparam logic [11:0] ERA5_YEAR  = 12'd2000;
    localparam logic [17:0] Q4Y_RCP    = 18'd183860;
    localparam int          Q4Y_SH     = 28;
    localparam logic [17:0] YEAR_RCP   = 18'd183860;
    localparam int          YEAR_SH    = 26;
    localparam logic [17:0] CENT_1     = 18'd36524;
    localparam logic [17:0] CENT_2     = 18'd73048;
    localparam logic [17:0] CENT_3     = 18'd109572;
    localparam logic [17:0] ERA_LAST   = 18'd146096;
    localparam logic [8:0]  DAYS_YEAR  = 9'd365;
    localparam logic [10:0] MON_RCP    = 11'd1714;
    localparam int          MON_SH     = 18;

    // Weekday: (day + 4) mod 7.
    localparam logic [16:0] WEEK_RCP   = 17'd74899;
    localparam int          WEEK_SH    = 19;
    localparam logic [2:0]  DAYS_WEEK  = 3'd7;
    localparam logic [2:0]  EPOCH_WDAY = 3'd4;

    // Date part of a result word.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [WDAY_W-1:0]  weekday;
    } t_date;

    // Time-of-day part of a result word.
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SECN_W-1:0] second;
    } t_hms;

    // First day of each March-based month within the year.
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
        logic [DOY_W-1:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/epoch_to_calendar_datetime_core.sv]
// Channel  | Handshake         | Words
// ---------+-------------------+---------------------------------------------
// input    | start, busy       | i_epoch_seconds
// result   | o_valid (strobe)  | o_year, o_month, o_day_of_month, o_hour,
//          |                   | o_minute, o_second, o_weekday
//
// One word is taken every cycle; busy is always low.
// Each result is set by the nine-stage date path (day split, era,
// leap corrections, year, month).
// Reset clears the valid pipeline only; data stages carry no reset.
// The result is shown for one cycle and the receiver cannot stall it.
`default_nettype none
`include "epoch_to_calendar_datetime_core_defines.svh"

module epoch_to_calendar_datetime_core import ecd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [SEC_W-1:0]   i_epoch_seconds,
    output logic                    o_valid,
    output logic [YEAR_W-1:0]       o_year,
    output logic [MONTH_W-1:0]      o_month,
    output logic [DOM_W-1:0]        o_day_of_month,
    output logic [HOUR_W-1:0]       o_hour,
    output logic [MIN_W-1:0]        o_minute,
    output logic [SECN_W-1:0]       o_second,
    output logic [WDAY_W-1:0]       o_weekday
);

    logic [DAY_W-1:0]   day;
    logic [TOD_W-1:0]   tod;
    t_date              date;
    t_hms               hms;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    // The pipeline never stalls, so it always accepts.
    assign busy = 1'b0;

    // Whole days and second of the day.
    ecd_daysplit u_daysplit (
        .i_clk  (i_clk),
        .i_secs (i_epoch_seconds),
        .o_day  (day),
        .o_tod  (tod)
    );

    // Hour, minute and second.
    ecd_clock u_clock (
        .i_clk (i_clk),
        .i_tod (tod),
        .o_hms (hms)
    );

    // Year, month, day of month and weekday.
    ecd_civil u_civil (
        .i_clk  (i_clk),
        .i_day  (day),
        .o_date (date)
    );

    // Valid bits travel alongside the data stages.
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid        = r_vld[LATENCY-1];
    assign o_year         = date.year;
    assign o_month        = date.month;
    assign o_day_of_month = date.day_of_month;
    assign o_weekday      = date.weekday;
    assign o_hour         = hms.hour;
    assign o_minute       = hms.minute;
    assign o_second       = hms.second;

    `ECD_ASSERT_PROP(a_latency, i_clk, i_rst_n, start |-> ##(LATENCY) o_valid)
    `ECD_ASSERT_IMP(a_date_range, i_clk, i_rst_n, o_valid, o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month >= 5'd1)
    `ECD_ASSERT_IMP(a_time_range, i_clk, i_rst_n, o_valid, o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59)
    `ECD_ASSERT_IMP(a_year_wday, i_clk, i_rst_n, o_valid, o_year >= 12'd1970 && o_year <= 12'd2106 && o_weekday <= 3'd6)

endmodule

`default_nettype wire

[rtl/ecd_daysplit.sv]
`default_nettype none

module ecd_daysplit import ecd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [SEC_W-1:0] i_secs,
    output logic [DAY_W-1:0]      o_day,
    output logic [TOD_W-1:0]      o_tod
);

    logic [24:0]       n_s1_x;
    logic [50:0]       n_s1_prod;
    logic [DAY_W-1:0]  n_s1_day;
    logic [24:0]       r_s1_x;
    logic [6:0]        r_s1_lo;
    logic [DAY_W-1:0]  r_s1_day;
    logic [24:0]       n_s2_rem;
    logic [TOD_W-1:0]  n_s2_tod;
    logic [DAY_W-1:0]  r_day;
    logic [TOD_W-1:0]  r_tod;

    // The low seven bits pass through; the rest is divided by 675 by reciprocal.
    always_comb begin
        n_s1_x    = i_secs[SEC_W-1:7];
        n_s1_prod = 51'(n_s1_x) * 51'(DAY_RCP);
        n_s1_day  = n_s1_prod[DAY_SH +: DAY_W];
    end

    // The remainder of the division forms the upper bits of the second of the day.
    always_comb begin
        n_s2_rem = r_s1_x - 25'(r_s1_day) * 25'(DAY_ODD);
        n_s2_tod = {n_s2_rem[9:0], r_s1_lo};
    end

    always_ff @(posedge i_clk) begin
        r_s1_x   <= n_s1_x;
        r_s1_lo  <= i_secs[6:0];
        r_s1_day <= n_s1_day;
        r_day    <= r_s1_day;
        r_tod    <= n_s2_tod;
    end

    assign o_day = r_day;
    assign o_tod = r_tod;

endmodule

`default_nettype wire

[rtl/ecd_clock.sv]
`default_nettype none

module ecd_clock import ecd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [TOD_W-1:0] i_tod,
    output t_hms                  o_hms
);

    localparam int DLY = 3;

    logic [33:0]       n_k1_prod;
    logic [TOD_W-1:0]  r_k1_tod;
    logic [HOUR_W-1:0] r_k1_hour;
    logic [16:0]       n_k2_rem;
    logic [HOUR_W-1:0] r_k2_hour;
    logic [11:0]       r_k2_remh;
    logic [24:0]       n_k3_prod;
    logic [HOUR_W-1:0] r_k3_hour;
    logic [11:0]       r_k3_remh;
    logic [MIN_W-1:0]  r_k3_min;
    logic [11:0]       n_k4_sec;
    t_hms              r_hms_dly [DLY+1];

    // Hour by reciprocal multiplication.
    assign n_k1_prod = 34'(i_tod) * 34'(HOUR_RCP);

    // Seconds within the hour.
    assign n_k2_rem  = r_k1_tod - 17'(r_k1_hour) * 17'(SEC_HOUR);

    // Minute by reciprocal multiplication.
    assign n_k3_prod = 25'(r_k2_remh) * 25'(MIN_RCP);

    // Seconds within the minute.
    assign n_k4_sec  = r_k3_remh - 12'(r_k3_min) * 12'(SEC_MIN);

    always_ff @(posedge i_clk) begin
        r_k1_tod            <= i_tod;
        r_k1_hour           <= n_k1_prod[HOUR_SH +: HOUR_W];
        r_k2_hour           <= r_k1_hour;
        r_k2_remh           <= n_k2_rem[11:0];
        r_k3_hour           <= r_k2_hour;
        r_k3_remh           <= r_k2_remh;
        r_k3_min            <= n_k3_prod[MIN_SH +: MIN_W];
        r_hms_dly[0].hour   <= r_k3_hour;
        r_hms_dly[0].minute <= r_k3_min;
        r_hms_dly[0].second <= n_k4_sec[SECN_W-1:0];
        // Delay line to line up with the date path.
        for (int i = 1; i <= DLY; i++) begin
            r_hms_dly[i] <= r_hms_dly[i-1];
        end
    end

    assign o_hms = r_hms_dly[DLY];

endmodule

`default_nettype wire

[rtl/ecd_civil.sv]
`default_nettype none

module ecd_civil import ecd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [DAY_W-1:0] i_day,
    output t_date                 o_date
);

    localparam int WDLY = 5;

    logic [19:0]        n_c1_shift;
    logic               n_c1_era;
    logic [19:0]        n_c1_in_era;
    logic               r_c1_era;
    logic [ERA_W-1:0]   r_c1_in_era;
    logic [35:0]        n_c2_prod;
    logic [2:0]         n_c2_b;
    logic               r_c2_era;
    logic [ERA_W-1:0]   r_c2_in_era;
    logic [6:0]         r_c2_a;
    logic [2:0]         r_c2_b;
    logic               r_c2_c;
    logic [ERA_W-1:0]   n_c3_t;
    logic               r_c3_era;
    logic [ERA_W-1:0]   r_c3_in_era;
    logic [ERA_W-1:0]   r_c3_t;
    logic [35:0]        n_c4_prod;
    logic               r_c4_era;
    logic [ERA_W-1:0]   r_c4_in_era;
    logic [YOE_W-1:0]   r_c4_yoe;
    logic [1:0]         n_c5_cent;
    logic [ERA_W-1:0]   n_c5_ystart;
    logic [ERA_W-1:0]   n_c5_doy;
    logic               r_c5_era;
    logic [YOE_W-1:0]   r_c5_yoe;
    logic [DOY_W-1:0]   r_c5_doy;
    logic [10:0]        n_c6_y5;
    logic [21:0]        n_c6_prod;
    logic               r_c6_era;
    logic [YOE_W-1:0]   r_c6_yoe;
    logic [DOY_W-1:0]   r_c6_doy;
    logic [3:0]         r_c6_mp;
    logic [MONTH_W-1:0] n_c7_month;
    logic [DOY_W-1:0]   n_c7_dom;
    logic [YEAR_W-1:0]  n_c7_year;
    logic [16:0]        n_w1_d4;
    logic [33:0]        n_w1_prod;
    logic [16:0]        r_w1_d4;
    logic [12:0]        r_w1_q;
    logic [16:0]        n_w2_wd;
    logic [WDAY_W-1:0]  r_wd_dly [WDLY];
    t_date              r_date;

    // Shift to a March-based count from year 0; the input range spans only eras 4 and 5.
    always_comb begin
        n_c1_shift  = 20'(i_day) + SHIFT_0000;
        n_c1_era    = (n_c1_shift >= ERA5_BASE);
        n_c1_in_era = n_c1_shift - (n_c1_era ? ERA5_BASE : ERA4_BASE);
    end

    // Leap-day corrections: four-year count by reciprocal, centuries by compare.
    always_comb begin
        n_c2_prod = 36'(r_c1_in_era) * 36'(Q4Y_RCP);
        n_c2_b    = 3'(r_c1_in_era >= CENT_1) + 3'(r_c1_in_era >= CENT_2)
                  + 3'(r_c1_in_era >= CENT_3) + 3'(r_c1_in_era >= ERA_LAST);
    end

    // Day count with leap days removed.
    assign n_c3_t = r_c2_in_era - 18'(r_c2_a) + 18'(r_c2_b) - 18'(r_c2_c);

    // Year of era by reciprocal of 365.
    assign n_c4_prod = 36'(r_c3_t) * 36'(YEAR_RCP);

    // Day of the March-based year.
    always_comb begin
        n_c5_cent   = 2'(r_c4_yoe >= 9'd100) + 2'(r_c4_yoe >= 9'd200)
                    + 2'(r_c4_yoe >= 9'd300);
        n_c5_ystart = 18'(r_c4_yoe) * 18'(DAYS_YEAR) + 18'(r_c4_yoe[YOE_W-1:2])
                    - 18'(n_c5_cent);
        n_c5_doy    = r_c4_in_era - n_c5_ystart;
    end

    // March-based month index.
    always_comb begin
        n_c6_y5   = 11'(r_c5_doy) * 11'd5 + 11'd2;
        n_c6_prod = 22'(n_c6_y5) * 22'(MON_RCP);
    end

    // Calendar month, day and year.
    always_comb begin
        n_c7_month = (r_c6_mp < 4'd10) ? r_c6_mp + 4'd3 : r_c6_mp - 4'd9;
        n_c7_dom   = r_c6_doy - month_start(r_c6_mp) + 9'd1;
        n_c7_year  = 12'(r_c6_yoe) + (r_c6_era ? ERA5_YEAR : ERA4_YEAR)
                   + 12'(n_c7_month <= 4'd2);
    end

    // Weekday: quotient by seven in the first stage, remainder in the second.
    always_comb begin
        n_w1_d4   = 17'(i_day) + 17'(EPOCH_WDAY);
        n_w1_prod = 34'(n_w1_d4) * 34'(WEEK_RCP);
        n_w2_wd   = r_w1_d4 - 17'(r_w1_q) * 17'(DAYS_WEEK);
    end

    always_ff @(posedge i_clk) begin
        r_c1_era            <= n_c1_era;
        r_c1_in_era         <= n_c1_in_era[ERA_W-1:0];
        r_c2_era            <= r_c1_era;
        r_c2_in_era         <= r_c1_in_era;
        r_c2_a              <= n_c2_prod[Q4Y_SH +: 7];
        r_c2_b              <= n_c2_b;
        r_c2_c              <= (r_c1_in_era == ERA_LAST);
        r_c3_era            <= r_c2_era;
        r_c3_in_era         <= r_c2_in_era;
        r_c3_t              <= n_c3_t;
        r_c4_era            <= r_c3_era;
        r_c4_in_era         <= r_c3_in_era;
        r_c4_yoe            <= n_c4_prod[YEAR_SH +: YOE_W];
        r_c5_era            <= r_c4_era;
        r_c5_yoe            <= r_c4_yoe;
        r_c5_doy            <= n_c5_doy[DOY_W-1:0];
        r_c6_era            <= r_c5_era;
        r_c6_yoe            <= r_c5_yoe;
        r_c6_doy            <= r_c5_doy;
        r_c6_mp             <= n_c6_prod[MON_SH +: 4];
        r_date.year         <= n_c7_year;
        r_date.month        <= n_c7_month;
        r_date.day_of_month <= n_c7_dom[DOM_W-1:0];
        r_date.weekday      <= r_wd_dly[WDLY-1];
        r_w1_d4             <= n_w1_d4;
        r_w1_q              <= n_w1_prod[WEEK_SH +: 13];
        r_wd_dly[0]         <= n_w2_wd[WDAY_W-1:0];
        // Weekday waits for the date stages.
        for (int i = 1; i < WDLY; i++) begin
            r_wd_dly[i] <= r_wd_dly[i-1];
        end
    end

    assign o_date = r_date;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ecd_pkg::*;

    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_HR  = 3600;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned DAYS_TO_0000 = 719468;
    localparam int unsigned ERA_DAYS     = 146097;
    localparam int unsigned LAST_DAY     = 49710;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int          RANDOM_WORDS = 232;

    // Corner timestamps: range ends, unit roll-overs, leap and non-leap
    // February ends, a leap-year December close and the 2038 boundary.
    localparam logic [SEC_W-1:0] CORNER_STAMPS [21] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd68169600,   32'd946684799,  32'd951782400,  32'd951868800,
        32'd1735689599, 32'd2147483647, 32'd2147483648, 32'd4107542399,
        32'd4107542400, 32'd4294944000, 32'hAAAAAAAA,   32'h55555555,
        32'hFFFFFFFF
    };

    // One expected or observed result, in port order.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SECN_W-1:0]  second;
        logic [WDAY_W-1:0]  weekday;
    } t_calendar;

    // Holds the calendar results still owed by the block and compares
    // each strobed result with the oldest one.
    class datetime_scoreboard;
        t_calendar   owed_q[$];
        int unsigned n_errors;
        int unsigned n_words;
        int unsigned n_checked;

        // Civil date by the March-based era split; time of day by plain
        // division; weekday counted from a Thursday epoch.
        static function t_calendar calendar_of(logic [SEC_W-1:0] stamp);
            int unsigned secs, day_num, tod, shifted, era, doe, yoe, doy, mp, mon;
            t_calendar   cal;
            secs    = stamp;
            day_num = secs / SECS_PER_DAY;
            tod     = secs % SECS_PER_DAY;
            shifted = day_num + DAYS_TO_0000;
            era     = shifted / ERA_DAYS;
            doe     = shifted - era * ERA_DAYS;
            yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp      = (5 * doy + 2) / 153;
            mon     = (mp < 10) ? mp + 3 : mp - 9;
            cal.year         = YEAR_W'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
            cal.month        = MONTH_W'(mon);
            cal.day_of_month = DOM_W'(doy - (153 * mp + 2) / 5 + 1);
            cal.hour         = HOUR_W'(tod / SECS_PER_HR);
            cal.minute       = MIN_W'((tod % SECS_PER_HR) / SECS_PER_MIN);
            cal.second       = SECN_W'(tod % SECS_PER_MIN);
            cal.weekday      = WDAY_W'((day_num + 4) % 7);
            return cal;
        endfunction

        function void note_failure(string what);
            n_errors++;
            if (n_errors <= REPORT_MAX) begin
                $display("%s", what);
            end
        endfunction

        function void note_word(logic [SEC_W-1:0] stamp);
            owed_q.push_back(calendar_of(stamp));
            n_words++;
        endfunction

        function void check_result(t_calendar got);
            t_calendar want;
            string     bad;
            if (owed_q.size() == 0) begin
                note_failure($sformatf("ERROR: result with nothing owed: %0d-%0d-%0d %0d:%0d:%0d",
                    got.year, got.month, got.day_of_month, got.hour, got.minute, got.second));
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            bad  = "";
            if (got.year !== want.year)                 bad = {bad, " year"};
            if (got.month !== want.month)               bad = {bad, " month"};
            if (got.day_of_month !== want.day_of_month) bad = {bad, " day"};
            if (got.hour !== want.hour)                 bad = {bad, " hour"};
            if (got.minute !== want.minute)             bad = {bad, " minute"};
            if (got.second !== want.second)             bad = {bad, " second"};
            if (got.weekday !== want.weekday)           bad = {bad, " weekday"};
            if (bad != "") begin
                note_failure($sformatf(
                    "MISMATCH result %0d:%s | want %0d-%0d-%0d %0d:%0d:%0d wd%0d | got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                    n_checked, bad,
                    want.year, want.month, want.day_of_month, want.hour, want.minute,
                    want.second, want.weekday,
                    got.year, got.month, got.day_of_month, got.hour, got.minute,
                    got.second, got.weekday));
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SEC_W-1:0]    i_epoch_seconds = '0;
    logic                o_valid;
    logic [YEAR_W-1:0]   o_year;
    logic [MONTH_W-1:0]  o_month;
    logic [DOM_W-1:0]    o_day_of_month;
    logic [HOUR_W-1:0]   o_hour;
    logic [MIN_W-1:0]    o_minute;
    logic [SECN_W-1:0]   o_second;
    logic [WDAY_W-1:0]   o_weekday;

    int unsigned         cycle_count = 0;
    datetime_scoreboard  book = new();

    epoch_to_calendar_datetime_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results still owed",
                     cycle_count, book.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            book.check_result({o_year, o_month, o_day_of_month, o_hour,
                               o_minute, o_second, o_weekday});
        end
    end

    // Offers one word, idling first with the given chance per cycle, and
    // records it once the block has taken it.
    task automatic send_word(input logic [SEC_W-1:0] stamp, input int idle_pct);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            start           <= 1'b0;
            i_epoch_seconds <= $urandom;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_epoch_seconds <= stamp;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        book.note_word(stamp);
    endtask

    // Random timestamps: mostly uniform over the full range, the rest at
    // day boundaries, near the top of the range or within the first days.
    task automatic run_phase(input int n_words, input int idle_pct);
        logic [SEC_W-1:0] stamp;
        longint unsigned  wide;
        for (int k = 0; k < n_words; k++) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4, 5: stamp = $urandom;
                6, 7: begin
                    wide = longint'($urandom_range(LAST_DAY, 0)) * SECS_PER_DAY;
                    if ($urandom_range(1, 0) == 1) begin
                        wide = wide + SECS_PER_DAY - 1;
                    end
                    if (wide > 64'hFFFF_FFFF) begin
                        wide = 64'hFFFF_FFFF;
                    end
                    stamp = wide[SEC_W-1:0];
                end
                8:       stamp = 32'hFFFFFFFF - $urandom_range(200000, 0);
                default: stamp = $urandom_range(1000000, 0);
            endcase
            send_word(stamp, idle_pct);
        end
    endtask

    initial begin
        // Synchronous reset held, then released.
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner dates back to back.
        foreach (CORNER_STAMPS[k]) begin
            send_word(CORNER_STAMPS[k], 0);
        end

        // Full rate, then a sparse sender, then the receiver phase (which
        // runs at full rate, as results cannot be held off), then a
        // moderately idle sender.
        run_phase(RANDOM_WORDS, 0);
        run_phase(RANDOM_WORDS, 58);
        run_phase(RANDOM_WORDS, 0);
        run_phase(RANDOM_WORDS, 28);
        @(negedge i_clk);
        start <= 1'b0;

        // Drain the pipeline, then allow for any stray strobe.
        while (book.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Converted %0d timestamps (corner dates and random words over four traffic phases).",
                 book.n_words);
        $display("Compared %0d results, %0d failures found.", book.n_checked, book.n_errors);
        if (book.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[epoch_to_calendar_datetime_core.f]
+incdir+rtl
rtl/ecd_pkg.sv
rtl/ecd_daysplit.sv
rtl/ecd_clock.sv
rtl/ecd_civil.sv
rtl/epoch_to_calendar_datetime_core.sv
bench/tb_top.sv
